// ===== hw/rtl/frt_pkg.sv =====
package frt_pkg;

  // Expected role of the next byte; the same codes label each output item
  typedef enum logic [3:0] {
    PH_ID_LO   = 4'd0,
    PH_ID_HI   = 4'd1,
    PH_TYPE    = 4'd2,
    PH_NFIELDS = 4'd3,
    PH_ENC     = 4'd4,
    PH_FTYPE   = 4'd5,
    PH_FLEN    = 4'd6,
    PH_VALUE   = 4'd7,
    PH_TRAIL   = 4'd8
  } phase_t;

  // Value kinds
  localparam logic [2:0] VK_NONE        = 3'd0;
  localparam logic [2:0] VK_OEM         = 3'd1;
  localparam logic [2:0] VK_UNSUPPORTED = 3'd7;

  localparam logic [7:0]  TYPE_GENERAL    = 8'd1;
  localparam logic [7:0]  TYPE_OEM        = 8'd254;
  localparam logic [15:0] MIN_RECORD_ROOM = 16'd8;
  localparam logic [7:0]  ENC_FIRST_KNOWN = 8'd1;
  localparam logic [7:0]  ENC_LAST_KNOWN  = 8'h05;

  // Parser state carried from item to item
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  kind_of_record;
    logic [7:0]  fields_left;
    logic [7:0]  enc_code;
    logic [7:0]  value_bytes_left;
    logic [15:0] record_count;
    logic [7:0]  field_count;
  } state_t;

  // Labels of one classified byte
  typedef struct packed {
    logic [3:0]  byte_role;
    logic [2:0]  value_kind;
    logic [15:0] record_number;
    logic [7:0]  field_number;
    logic        record_done;
    logic        table_truncated;
  } label_t;

  function automatic logic has_fields(input logic [7:0] kind);
    return (kind == TYPE_GENERAL) || (kind == TYPE_OEM);
  endfunction

  // OEM bytes, a known encoding shifted up by one, or unsupported
  function automatic logic [2:0] kind_of_value(input logic [7:0] kind,
                                               input logic [7:0] enc);
    logic [7:0] k;
    k = enc + 8'd1;
    if (kind == TYPE_OEM) begin
      return VK_OEM;
    end else if (enc >= ENC_FIRST_KNOWN && enc <= ENC_LAST_KNOWN) begin
      return k[2:0];
    end else begin
      return VK_UNSUPPORTED;
    end
  endfunction

endpackage

// ===== hw/rtl/frt_step.sv =====
module frt_step (
  input  frt_pkg::state_t st,
  input  logic [7:0]      table_byte,
  input  logic [15:0]     bytes_remaining,
  input  logic            table_start,
  output frt_pkg::state_t st_nxt,
  output frt_pkg::label_t label
);
  import frt_pkg::*;

  always_comb begin
    state_t     s;
    logic       last;
    logic       done;
    logic [7:0] fl;
    logic [7:0] vl;

    s    = st;
    last = (bytes_remaining <= 16'd1);
    done = 1'b0;
    fl   = st.fields_left - 8'd1;
    vl   = st.value_bytes_left - 8'd1;

    label.byte_role       = PH_TRAIL;
    label.value_kind      = VK_NONE;
    label.field_number    = 8'd0;
    label.table_truncated = 1'b0;

    // Restart parsing on a new table
    if (table_start) begin
      s.phase        = PH_ID_LO;
      s.record_count = 16'd0;
    end
    label.record_number = s.record_count;

    // Classify the byte and advance the phase
    unique case (s.phase)
      PH_ID_LO: begin
        if (bytes_remaining >= MIN_RECORD_ROOM) begin
          label.byte_role = PH_ID_LO;
          s.field_count   = 8'd0;
          s.phase         = PH_ID_HI;
        end else begin
          label.byte_role = PH_TRAIL;
          s.phase         = PH_TRAIL;
        end
      end
      PH_ID_HI: begin
        label.byte_role = PH_ID_HI;
        s.phase         = PH_TYPE;
      end
      PH_TYPE: begin
        label.byte_role  = PH_TYPE;
        s.kind_of_record = table_byte;
        s.phase          = PH_NFIELDS;
      end
      PH_NFIELDS: begin
        label.byte_role = PH_NFIELDS;
        s.fields_left   = table_byte;
        s.phase         = PH_ENC;
      end
      PH_ENC: begin
        label.byte_role = PH_ENC;
        s.enc_code      = table_byte;
        if (has_fields(s.kind_of_record) && s.fields_left != 8'd0) begin
          s.field_count = 8'd0;
          s.phase       = PH_FTYPE;
        end else begin
          done = 1'b1;
        end
      end
      PH_FTYPE: begin
        label.byte_role    = PH_FTYPE;
        label.field_number = s.field_count;
        s.phase            = PH_FLEN;
      end
      PH_FLEN: begin
        label.byte_role    = PH_FLEN;
        label.field_number = s.field_count;
        s.value_bytes_left = table_byte;
        if (table_byte == 8'd0) begin
          // Empty field closes at once
          s.fields_left = fl;
          if (fl == 8'd0) begin
            done = 1'b1;
          end else begin
            s.field_count = s.field_count + 8'd1;
            s.phase       = PH_FTYPE;
          end
        end else begin
          s.phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        label.byte_role    = PH_VALUE;
        label.field_number = s.field_count;
        label.value_kind   = kind_of_value(s.kind_of_record, s.enc_code);
        s.value_bytes_left = vl;
        if (vl == 8'd0) begin
          s.fields_left = fl;
          if (fl == 8'd0) begin
            done = 1'b1;
          end else begin
            s.field_count = s.field_count + 8'd1;
            s.phase       = PH_FTYPE;
          end
        end
      end
      default: begin
        label.byte_role = PH_TRAIL;
        s.phase         = PH_TRAIL;
      end
    endcase

    // Close the record, saturating the count
    if (done) begin
      s.phase       = PH_ID_LO;
      s.field_count = 8'd0;
      if (s.record_count != 16'hFFFF) begin
        s.record_count = s.record_count + 16'd1;
      end
    end

    // Flag an unfinished record and rearm for the next table
    if (last) begin
      label.table_truncated = (s.phase != PH_ID_LO) && (s.phase != PH_TRAIL);
      s.phase        = PH_ID_LO;
      s.record_count = 16'd0;
      s.field_count  = 8'd0;
    end

    label.record_done = done;
    st_nxt            = s;
  end

endmodule

// ===== hw/rtl/fru_record_table_parser.sv =====
// FRU record table parser: labels each table byte with its role (set id, type,
// field count, encoding, field type, field length, value or trailing), the kind
// of a value byte, the record and field numbers, and flags record completion and
// a table that ends inside a record. Bytes pass through an input register, one
// step of parser logic and an output register; the parser state updates once per
// byte, so one byte is accepted every clock cycle while the output register is not
// held full by a low out_tready. The input side keeps accepting while a result
// waits in the output register as long as the input register is free.
module fru_record_table_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] table_byte, [23:8] bytes_remaining
  input  logic [0:0]  in_tuser,   // [0] table_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] byte_role, [6:4] value_kind,
                                  // [22:7] record_number, [30:23] field_number,
                                  // [38:31] byte_out, [39] zero
  output logic [1:0]  out_tuser   // [0] record_done, [1] table_truncated
);
  import frt_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic [15:0] in_rem_r;
  logic        in_start_r;
  state_t      st_r;
  state_t      st_nxt;
  label_t      label;
  logic        out_v_r;
  label_t      out_label_r;
  logic [7:0]  out_byte_r;
  logic        advance;

  // Output register frees when empty or taken
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;

  frt_step u_step (
    .st              (st_r),
    .table_byte      (in_byte_r),
    .bytes_remaining (in_rem_r),
    .table_start     (in_start_r),
    .st_nxt          (st_nxt),
    .label           (label)
  );

  // Hold valid bits and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{phase: PH_ID_LO, record_count: 16'd0, default: 8'd0};
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
        if (in_v_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata[7:0];
      in_rem_r   <= in_tdata[23:8];
      in_start_r <= in_tuser[0];
    end
    if (advance && in_v_r) begin
      out_label_r <= label;
      out_byte_r  <= in_byte_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_byte_r, out_label_r.field_number,
                       out_label_r.record_number, out_label_r.value_kind,
                       out_label_r.byte_role};
  assign out_tuser  = {out_label_r.table_truncated, out_label_r.record_done};

endmodule
